// ----- rtl/core/ipsprb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipsprb_pkg;

    // Input commands
    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_PAIR  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_LITERAL   = 3'd1,
        KIND_RLE       = 3'd2,
        KIND_EOF       = 3'd3,
        KIND_TRUNCATE  = 3'd4,
        KIND_TOO_LARGE = 3'd5
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TARGET_LENGTH = 2'd1;
    localparam logic [1:0] CFG_SIZE_LIMIT    = 2'd2;

    localparam logic [31:0] SIZE_LIMIT_RESET = 32'hFFFF_FFFF;

    // Offset whose three bytes spell "EOF"; no record may start there
    localparam logic [23:0] EOF_OFFSET = 24'h454F46;
    localparam logic [15:0] MAX_RUN    = 16'hFFFF;
    localparam logic [15:0] RLE_MIN_COUNT = 16'd4;

    // Largest addressable target, and the largest one that may be truncated to
    localparam logic [24:0] TARGET_LIMIT       = 25'h100_0000;
    localparam logic [24:0] TARGET_LIMIT_SHORT = 25'h0FF_FFFF;

    // Patch byte costs
    localparam logic [31:0] HEADER_COST  = 32'd5;
    localparam logic [16:0] LIT_OVERHEAD = 17'd5;
    localparam logic [16:0] RLE_COST     = 17'd8;
    localparam logic [17:0] EOF_COST     = 18'd3;
    localparam logic [17:0] TRUNC_COST   = 18'd3;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  target_byte;
        logic [7:0]  source_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] record_offset;
        logic [15:0] record_count;
        logic [7:0]  fill_value;
        logic [31:0] total_bytes;
    } result_t;

    // All results caused by one item, rec[0] first
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     rec;
    } batch_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipsprb_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsprb_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire ipsprb_pkg::item_t  s_item,
    output logic                    s_ready,
    input  wire logic               take,
    output logic                    item_valid,
    output ipsprb_pkg::item_t       item
);

    logic              valid_reg;
    logic              valid_next;
    ipsprb_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipsprb_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsprb_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               fire,
    input  wire ipsprb_pkg::item_t  item,
    output ipsprb_pkg::batch_t      batch
);

    logic [31:0] source_length_reg;
    logic [24:0] target_length_reg;
    logic [31:0] size_limit_reg;

    logic [24:0] position_reg,        position_next;
    logic [23:0] run_start_reg,       run_start_next;
    logic        in_run_reg,          in_run_next;
    logic [7:0]  run_fill_reg,        run_fill_next;
    logic        run_all_same_reg,    run_all_same_next;
    logic [7:0]  previous_target_reg, previous_target_next;
    logic [31:0] bytes_emitted_reg,   bytes_emitted_next;
    logic        job_active_reg,      job_active_next;

    function automatic ipsprb_pkg::result_t make_rec(
        ipsprb_pkg::kind_t kind,
        logic [23:0]       off,
        logic [15:0]       cnt,
        logic [7:0]        fill,
        logic [31:0]       total
    );
        ipsprb_pkg::result_t r;
        r.kind          = kind;
        r.record_offset = off;
        r.record_count  = cnt;
        r.fill_value    = fill;
        r.total_bytes   = total;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_length_reg <= '0;
            target_length_reg <= '0;
            size_limit_reg    <= ipsprb_pkg::SIZE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ipsprb_pkg::CFG_SOURCE_LENGTH: source_length_reg <= cfg_wr_data;
                ipsprb_pkg::CFG_TARGET_LENGTH: target_length_reg <= cfg_wr_data[24:0];
                ipsprb_pkg::CFG_SIZE_LIMIT:    size_limit_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [24:0]         run_len;
        logic [15:0]         run_count;
        logic                close_rle;
        logic [16:0]         close_cost;
        logic [17:0]         eof_cost;
        logic [17:0]         trunc_cost;
        logic [32:0]         limit_ext;
        logic [32:0]         sum1;
        logic [32:0]         sum2;
        logic [32:0]         sum3;
        logic                fit1;
        logic                fit2;
        logic                fit3;
        logic                changed;
        logic                start_at_eof;
        logic [23:0]         start_off;
        logic [7:0]          start_fill;
        logic                start_same;
        logic                oversized;
        logic                ok;
        logic [1:0]          n;
        logic [31:0]         base_total;
        ipsprb_pkg::result_t close_rec;

        // current run, closed at the current position
        run_len    = position_reg - {1'b0, run_start_reg};
        run_count  = run_len[15:0];
        close_rle  = (run_count >= ipsprb_pkg::RLE_MIN_COUNT) && run_all_same_reg;
        close_cost = close_rle ? ipsprb_pkg::RLE_COST
                               : ipsprb_pkg::LIT_OVERHEAD + {1'b0, run_count};
        close_rec  = make_rec(close_rle ? ipsprb_pkg::KIND_RLE : ipsprb_pkg::KIND_LITERAL,
                              run_start_reg, run_count,
                              close_rle ? run_fill_reg : 8'd0, 32'd0);

        // running totals for close, eof and truncate, all from the same base
        eof_cost   = in_run_reg ? {1'b0, close_cost} + ipsprb_pkg::EOF_COST
                                : ipsprb_pkg::EOF_COST;
        trunc_cost = eof_cost + ipsprb_pkg::TRUNC_COST;
        limit_ext  = {1'b0, size_limit_reg};
        sum1       = {1'b0, bytes_emitted_reg} + {16'd0, close_cost};
        sum2       = {1'b0, bytes_emitted_reg} + {15'd0, eof_cost};
        sum3       = {1'b0, bytes_emitted_reg} + {15'd0, trunc_cost};
        fit1       = sum1 <= limit_ext;
        fit2       = sum2 <= limit_ext;
        fit3       = sum3 <= limit_ext;
        close_rec.total_bytes = sum1[31:0];

        changed = ({7'd0, position_reg} >= source_length_reg)
                  || (item.source_byte != item.target_byte);

        // a run starting on the "EOF" offset backs up one byte
        start_at_eof = (position_reg == {1'b0, ipsprb_pkg::EOF_OFFSET});
        start_off    = start_at_eof ? ipsprb_pkg::EOF_OFFSET - 24'd1 : position_reg[23:0];
        start_fill   = start_at_eof ? previous_target_reg : item.target_byte;
        start_same   = start_at_eof ? (item.target_byte == previous_target_reg) : 1'b1;

        oversized = (target_length_reg > ipsprb_pkg::TARGET_LIMIT)
                    || (({7'd0, target_length_reg} < source_length_reg)
                        && (target_length_reg > ipsprb_pkg::TARGET_LIMIT_SHORT));

        ok         = 1'b1;
        n          = 2'd0;
        base_total = bytes_emitted_reg;

        position_next        = position_reg;
        run_start_next       = run_start_reg;
        in_run_next          = in_run_reg;
        run_fill_next        = run_fill_reg;
        run_all_same_next    = run_all_same_reg;
        previous_target_next = previous_target_reg;
        bytes_emitted_next   = bytes_emitted_reg;
        job_active_next      = job_active_reg;
        batch                = '0;

        if (fire) begin
            unique case (item.cmd)
                ipsprb_pkg::CMD_BEGIN: begin
                    position_next        = '0;
                    run_start_next       = '0;
                    in_run_next          = 1'b0;
                    run_fill_next        = '0;
                    run_all_same_next    = 1'b0;
                    previous_target_next = '0;
                    bytes_emitted_next   = '0;
                    job_active_next      = 1'b0;
                    batch.count          = 2'd1;
                    if (oversized || (size_limit_reg < ipsprb_pkg::HEADER_COST)) begin
                        batch.rec[0] = make_rec(ipsprb_pkg::KIND_TOO_LARGE,
                                                24'd0, 16'd0, 8'd0, 32'd0);
                    end else begin
                        batch.rec[0] = make_rec(ipsprb_pkg::KIND_HEADER, 24'd0, 16'd0,
                                                8'd0, ipsprb_pkg::HEADER_COST);
                        bytes_emitted_next = ipsprb_pkg::HEADER_COST;
                        job_active_next    = 1'b1;
                    end
                end
                ipsprb_pkg::CMD_PAIR: begin
                    if (job_active_reg && (position_reg < target_length_reg)) begin
                        if (in_run_reg) begin
                            if (!changed || (run_len >= {9'd0, ipsprb_pkg::MAX_RUN})) begin
                                batch.count = 2'd1;
                                if (fit1) begin
                                    batch.rec[0]       = close_rec;
                                    bytes_emitted_next = sum1[31:0];
                                    in_run_next        = 1'b0;
                                    // full-length run: the changed byte opens the next one
                                    if (changed) begin
                                        in_run_next       = 1'b1;
                                        run_start_next    = start_off;
                                        run_fill_next     = start_fill;
                                        run_all_same_next = start_same;
                                    end
                                end else begin
                                    batch.rec[0] = make_rec(ipsprb_pkg::KIND_TOO_LARGE,
                                                            24'd0, 16'd0, 8'd0,
                                                            bytes_emitted_reg);
                                    job_active_next = 1'b0;
                                    in_run_next     = 1'b0;
                                    ok              = 1'b0;
                                end
                            end else if (item.target_byte != run_fill_reg) begin
                                run_all_same_next = 1'b0;
                            end
                        end else if (changed) begin
                            in_run_next       = 1'b1;
                            run_start_next    = start_off;
                            run_fill_next     = start_fill;
                            run_all_same_next = start_same;
                        end
                        if (ok) begin
                            previous_target_next = item.target_byte;
                            position_next        = position_reg + 25'd1;
                        end
                    end
                end
                ipsprb_pkg::CMD_END: begin
                    if (job_active_reg) begin
                        if (in_run_reg) begin
                            n = 2'd1;
                            if (fit1) begin
                                batch.rec[0]       = close_rec;
                                base_total         = sum1[31:0];
                                bytes_emitted_next = sum1[31:0];
                            end else begin
                                batch.rec[0] = make_rec(ipsprb_pkg::KIND_TOO_LARGE,
                                                        24'd0, 16'd0, 8'd0,
                                                        bytes_emitted_reg);
                                ok = 1'b0;
                            end
                        end
                        if (ok) begin
                            if (fit2) begin
                                batch.rec[n] = make_rec(ipsprb_pkg::KIND_EOF, 24'd0,
                                                        16'd0, 8'd0, sum2[31:0]);
                                n = n + 2'd1;
                                bytes_emitted_next = sum2[31:0];
                                if ({7'd0, target_length_reg} < source_length_reg) begin
                                    if (fit3) begin
                                        batch.rec[n] = make_rec(ipsprb_pkg::KIND_TRUNCATE,
                                                                target_length_reg[23:0],
                                                                16'd0, 8'd0, sum3[31:0]);
                                        bytes_emitted_next = sum3[31:0];
                                    end else begin
                                        batch.rec[n] = make_rec(ipsprb_pkg::KIND_TOO_LARGE,
                                                                24'd0, 16'd0, 8'd0,
                                                                sum2[31:0]);
                                    end
                                    n = n + 2'd1;
                                end
                            end else begin
                                batch.rec[n] = make_rec(ipsprb_pkg::KIND_TOO_LARGE, 24'd0,
                                                        16'd0, 8'd0, base_total);
                                n = n + 2'd1;
                            end
                        end
                        batch.count     = n;
                        job_active_next = 1'b0;
                        in_run_next     = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg        <= '0;
            run_start_reg       <= '0;
            in_run_reg          <= 1'b0;
            run_fill_reg        <= '0;
            run_all_same_reg    <= 1'b0;
            previous_target_reg <= '0;
            bytes_emitted_reg   <= '0;
            job_active_reg      <= 1'b0;
        end else begin
            position_reg        <= position_next;
            run_start_reg       <= run_start_next;
            in_run_reg          <= in_run_next;
            run_fill_reg        <= run_fill_next;
            run_all_same_reg    <= run_all_same_next;
            previous_target_reg <= previous_target_next;
            bytes_emitted_reg   <= bytes_emitted_next;
            job_active_reg      <= job_active_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipsprb_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipsprb_out_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire ipsprb_pkg::batch_t  batch,
    output logic                     can_load,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ipsprb_pkg::result_t      head,
    output logic                     head_last
);

    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    ipsprb_pkg::result_t slot_reg [3];
    logic                pop;

    // a new batch goes in once the last result of the previous one leaves
    assign can_load  = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign m_valid   = (count_reg != 2'd0);
    assign pop       = m_valid && m_ready;
    assign head      = slot_reg[0];
    assign head_last = (count_reg == 2'd1);

    always_comb begin
        count_next = count_reg;
        if (load) begin
            count_next = batch.count;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                slot_reg[i] <= batch.rec[i];
            end
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ips_patch_record_builder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// IPS patch record builder. Feed one begin item, then one byte pair per
// target position (target byte in s_tdata[7:0], source byte in [15:8]), then
// one end item; the block answers with record descriptors: header, literal
// and RLE records, EOF marker, optional truncation length, or a too-large
// error, each with the running patch size. Literal data is not carried; the
// consumer copies it from the target image using offset and count. Items are
// taken one per cycle: byte pairs and begin give at most one result, so a
// byte stream runs at one pair per clock as long as m_tready stays high. An
// end item gives up to three results, drained one per cycle from the output
// queue while m_tready is high, and the next item is not taken until the last
// of them is leaving. The first result passes through the input register,
// then record logic into the output queue. m_tlast marks the final result of
// an item. Configuration registers are written through cfg_*; the user must do
// so only while no job work is pending, as the block itself does not enforce it.
module ips_patch_record_builder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] target_byte, [15:8] source_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [23:0] record_offset, [39:24] record_count,
                                        // [47:40] fill_value, [79:48] total_bytes
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);

    ipsprb_pkg::item_t   s_item;
    ipsprb_pkg::item_t   item;
    logic                item_valid;
    logic                take;
    logic                can_load;
    ipsprb_pkg::batch_t  batch;
    ipsprb_pkg::result_t head;

    always_comb begin
        s_item.cmd         = ipsprb_pkg::cmd_t'(s_tuser);
        s_item.target_byte = s_tdata[7:0];
        s_item.source_byte = s_tdata[15:8];
    end

    // item moves into the record logic when the output queue can take its batch
    assign take = item_valid && can_load;

    ipsprb_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_item     (s_item),
        .s_ready    (s_tready),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ipsprb_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fire        (take),
        .item        (item),
        .batch       (batch)
    );

    ipsprb_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .batch     (batch),
        .can_load  (can_load),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .head      (head),
        .head_last (m_tlast)
    );

    assign m_tdata = {head.total_bytes, head.fill_value, head.record_count,
                      head.record_offset};
    assign m_tuser = head.kind;

`ifndef ASSERT_OFF
    // a batch is loaded only over an empty queue or one losing its last result
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> (!m_tvalid || (m_tlast && m_tready)))
        else $error("output queue overwritten while results pending");

    // a too-large error always ends the results of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ipsprb_pkg::KIND_TOO_LARGE)) |-> m_tlast)
        else $error("too-large error not final result of item");

    // a header is alone and always accounts for the five header bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ipsprb_pkg::KIND_HEADER))
            |-> (m_tlast && (m_tdata[79:48] == 32'd5)))
        else $error("header result with wrong size or not alone");
`endif

endmodule

`default_nettype wire

// ----- verif/ipsprb_record_checker.sv -----
`timescale 1ns / 1ps

module ipsprb_record_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,

    output int          mismatches,
    output int          records_pending
);
    import ipsprb_pkg::*;

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] offset;
        logic [15:0] count;
        logic [7:0]  fill;
        logic [31:0] total;
        logic        last;
    } record_t;

    record_t records_due[$];
    int      results_seen = 0;

    // register mirror
    logic [31:0] src_len;
    logic [24:0] tgt_len;
    logic [31:0] lim;

    // job state
    logic [31:0] pos;
    logic [31:0] run_start;
    logic        in_run;
    logic [7:0]  run_fill;
    logic        run_same;
    logic [7:0]  prev_tgt;
    logic [31:0] patch_bytes;
    logic        job_on;

    task automatic report(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] record check: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void add_record(kind_t k, logic [31:0] off, logic [31:0] cnt,
                                       logic [7:0] f);
        record_t r;
        r.kind   = k;
        r.offset = off[23:0];
        r.count  = cnt[15:0];
        r.fill   = f;
        r.total  = patch_bytes;
        r.last   = 1'b0;
        records_due.push_back(r);
    endfunction

    // Add cost to the patch size, or flag too-large and drop the job.
    function automatic bit charge(logic [31:0] cost);
        if ({1'b0, patch_bytes} + {1'b0, cost} > {1'b0, lim}) begin
            add_record(KIND_TOO_LARGE, 32'd0, 32'd0, 8'd0);
            job_on = 1'b0;
            in_run = 1'b0;
            return 1'b0;
        end
        patch_bytes = patch_bytes + cost;
        return 1'b1;
    endfunction

    function automatic bit close_run(logic [31:0] stop);
        logic [31:0] cnt;
        cnt    = stop - run_start;
        in_run = 1'b0;
        if (cnt >= RLE_MIN_COUNT && run_same) begin
            if (!charge(RLE_COST))
                return 1'b0;
            add_record(KIND_RLE, run_start, cnt, run_fill);
        end else begin
            if (!charge(LIT_OVERHEAD + cnt))
                return 1'b0;
            add_record(KIND_LITERAL, run_start, cnt, 8'd0);
        end
        return 1'b1;
    endfunction

    // A run may not begin on the "EOF" offset; pull it back one byte.
    function automatic void open_run(logic [31:0] p, logic [7:0] t);
        in_run = 1'b1;
        if (p == {8'd0, EOF_OFFSET}) begin
            run_start = p - 1;
            run_fill  = prev_tgt;
            run_same  = (t == prev_tgt);
        end else begin
            run_start = p;
            run_fill  = t;
            run_same  = 1'b1;
        end
    endfunction

    function automatic void predict_records(logic [1:0] code, logic [7:0] t, logic [7:0] s);
        logic [31:0] p;
        bit          changed;
        bit          ok;
        int          first;
        record_t     r;
        first = records_due.size();
        case (code)
            CMD_BEGIN: begin
                pos         = '0;
                run_start   = '0;
                in_run      = 1'b0;
                run_fill    = '0;
                run_same    = 1'b0;
                prev_tgt    = '0;
                patch_bytes = '0;
                job_on      = 1'b0;
                if (tgt_len > TARGET_LIMIT ||
                    (tgt_len < src_len && tgt_len > TARGET_LIMIT_SHORT)) begin
                    add_record(KIND_TOO_LARGE, 32'd0, 32'd0, 8'd0);
                end else if (charge(HEADER_COST)) begin
                    job_on = 1'b1;
                    add_record(KIND_HEADER, 32'd0, 32'd0, 8'd0);
                end
            end
            CMD_PAIR: begin
                if (job_on && pos < tgt_len) begin
                    p       = pos;
                    changed = (p >= src_len) || (s != t);
                    ok      = 1'b1;
                    if (in_run) begin
                        if (!changed) begin
                            ok = close_run(p);
                        end else if (p - run_start < {16'd0, MAX_RUN}) begin
                            if (t != run_fill)
                                run_same = 1'b0;
                        end else begin
                            // run is full: close it and start the next at this byte
                            ok = close_run(p);
                            if (ok)
                                open_run(p, t);
                        end
                    end else if (changed) begin
                        open_run(p, t);
                    end
                    if (ok) begin
                        prev_tgt = t;
                        pos      = p + 1;
                    end
                end
            end
            CMD_END: begin
                if (job_on) begin
                    ok = 1'b1;
                    if (in_run)
                        ok = close_run(pos);
                    if (ok && charge(EOF_COST)) begin
                        add_record(KIND_EOF, 32'd0, 32'd0, 8'd0);
                        if (tgt_len < src_len && charge(TRUNC_COST))
                            add_record(KIND_TRUNCATE, {7'd0, tgt_len}, 32'd0, 8'd0);
                    end
                    job_on = 1'b0;
                    in_run = 1'b0;
                end
            end
            default: ;
        endcase
        if (records_due.size() > first) begin
            r      = records_due.pop_back();
            r.last = 1'b1;
            records_due.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        record_t want;
        if (!aresetn) begin
            src_len     = '0;
            tgt_len     = '0;
            lim         = SIZE_LIMIT_RESET;
            pos         = '0;
            run_start   = '0;
            in_run      = 1'b0;
            run_fill    = '0;
            run_same    = 1'b0;
            prev_tgt    = '0;
            patch_bytes = '0;
            job_on      = 1'b0;
        end else begin
            // results first: a result never belongs to an item taken this edge
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (records_due.size() == 0) begin
                    report($sformatf("result %0d (kind %0d) with nothing outstanding",
                                     results_seen, m_tuser));
                end else begin
                    want = records_due.pop_front();
                    if (m_tuser !== want.kind)
                        report($sformatf("result %0d: kind %0d, expected %0d",
                                         results_seen, m_tuser, want.kind));
                    if (m_tdata[23:0] !== want.offset)
                        report($sformatf("result %0d: offset %0h, expected %0h",
                                         results_seen, m_tdata[23:0], want.offset));
                    if (m_tdata[39:24] !== want.count)
                        report($sformatf("result %0d: count %0d, expected %0d",
                                         results_seen, m_tdata[39:24], want.count));
                    if (m_tdata[47:40] !== want.fill)
                        report($sformatf("result %0d: fill %0h, expected %0h",
                                         results_seen, m_tdata[47:40], want.fill));
                    if (m_tdata[79:48] !== want.total)
                        report($sformatf("result %0d: total %0d, expected %0d",
                                         results_seen, m_tdata[79:48], want.total));
                    if (m_tlast !== want.last)
                        report($sformatf("result %0d: last %0b, expected %0b",
                                         results_seen, m_tlast, want.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SOURCE_LENGTH: src_len = cfg_wr_data;
                    CFG_TARGET_LENGTH: tgt_len = cfg_wr_data[24:0];
                    CFG_SIZE_LIMIT:    lim     = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_records(s_tuser, s_tdata[7:0], s_tdata[15:8]);
        end
        records_pending = records_due.size();
    end

endmodule

// ----- verif/tb_ips_patch_record_builder_unit.sv -----
`timescale 1ns / 1ps

module tb_ips_patch_record_builder_unit;
    import ipsprb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    // leave a margin for block latency before touching registers
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    // slowest legal quiet stretch is the long receiver hold-off; allow ~5x
    localparam int WATCHDOG_LIMIT = 2000;
    // directed items and the tail of the last job bring the total near 310
    localparam int RANDOM_ITEMS   = 260;

    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;

    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = CFG_SOURCE_LENGTH;
    logic [31:0] cfg_wr_data = '0;

    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [7:0] target_byte, [15:8] source_byte
    logic [1:0]  s_tuser     = CMD_BEGIN;   // [1:0] cmd

    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;   // [23:0] record_offset, [39:24] record_count,
                            // [47:40] fill_value, [79:48] total_bytes
    logic [2:0]  m_tuser;   // [2:0] kind
    logic        m_tlast;

    int mismatches;
    int records_pending;

    // sender burst state, items handed over so far
    int burst_left  = 0;
    int items_sent  = 0;

    // set once to make the receiver back off for a long stretch
    bit hold_req    = 1'b0;

    int quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ips_patch_record_builder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ipsprb_record_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .records_pending (records_pending)
    );

    // Offer one item and wait for it to be taken. Called at a falling edge,
    // returns at the falling edge after the accept with tvalid still high so
    // back-to-back items never drop valid. A new burst may open with a gap.
    task automatic send_item(input logic [1:0] code, input logic [7:0] t, input logic [7:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {s, t};
        items_sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every outstanding record, then cover latency
    // of items that make no record (pairs) before anything else happens.
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (records_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // All three registers, one per cycle. Upper bits of the target length
    // word carry junk: only [24:0] belongs to the register.
    task automatic set_config(input logic [31:0] src, input logic [24:0] tgt,
                              input logic [31:0] lim);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SOURCE_LENGTH;
        cfg_wr_data <= src;
        @(negedge aclk);
        cfg_index   <= CFG_TARGET_LENGTH;
        cfg_wr_data <= {7'($urandom()), tgt};
        @(negedge aclk);
        cfg_index   <= CFG_SIZE_LIMIT;
        cfg_wr_data <= lim;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Begin, byte pairs, end. Changed/unchanged state is sticky so runs form;
    // repeat_pct controls how often the target byte repeats (RLE candidates).
    // noise_pct sprinkles random commands in, which may restart or kill the job.
    task automatic patch_job(input int pairs, input int change_pct, input int sticky_pct,
                             input int repeat_pct, input int noise_pct);
        logic [7:0] t;
        logic [7:0] s;
        logic [7:0] prev;
        bit         changed;
        prev    = 8'($urandom());
        changed = 1'b0;
        send_item(CMD_BEGIN, 8'($urandom()), 8'($urandom()));
        for (int i = 0; i < pairs; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(2'($urandom()), 8'($urandom()), 8'($urandom()));
            if ($urandom_range(0, 99) >= sticky_pct)
                changed = ($urandom_range(0, 99) < change_pct);
            t = ($urandom_range(0, 99) < repeat_pct) ? prev : 8'($urandom());
            s = changed ? (t ^ 8'($urandom_range(1, 255))) : t;
            send_item(CMD_PAIR, t, s);
            prev = t;
        end
        send_item(CMD_END, 8'($urandom()), 8'($urandom()));
    endtask

    // Receiver: segments of random length, each with its own stall pattern
    // (always ready, mostly ready, mostly stalled, toggling). One long
    // hold-off on request so the block backs up into its input.
    initial begin : receiver
        int seg;
        int mode;
        int held;
        seg  = 0;
        mode = 0;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && held < HOLD_CYCLES) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                if (seg == 0) begin
                    seg  = $urandom_range(10, 150);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Watchdog: too long with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** ips_patch_record_builder_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int          random_start;
        int          pairs;
        bit          pressure_done;
        logic [31:0] src;
        logic [24:0] tgt;
        logic [31:0] lim;

        pressure_done = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // Source 8, target 12: idle-block items, RLE, literal, past-source
        // bytes, early end.
        set_config(32'd8, 25'd12, ALL_ONES);
        send_item(CMD_PAIR, 8'hFF, 8'h00);       // idle: ignored
        send_item(CMD_END, 8'h00, 8'h00);        // idle: ignored
        send_item(CMD_UNKNOWN, 8'hA5, 8'h5A);    // unknown command
        send_item(CMD_BEGIN, 8'h00, 8'h00);      // header
        send_item(CMD_PAIR, 8'h00, 8'h00);       // unchanged
        repeat (4) send_item(CMD_PAIR, 8'hFF, 8'h00);   // four equal changed bytes
        send_item(CMD_PAIR, 8'h55, 8'h55);       // unchanged: closes the RLE run
        send_item(CMD_PAIR, 8'h12, 8'h34);
        send_item(CMD_PAIR, 8'h34, 8'h12);       // mixed bytes: literal
        send_item(CMD_PAIR, 8'h00, 8'h00);       // past source length: changed anyway
        send_item(CMD_END, 8'hFF, 8'hFF);        // early end closes the open run

        // Target shorter than source: begin while active, extra pair beyond
        // target length, end with three results (literal, EOF, truncate).
        settle();
        set_config(ALL_ONES, 25'd2, ALL_ONES);
        send_item(CMD_BEGIN, 8'hFF, 8'hFF);
        send_item(CMD_BEGIN, 8'h00, 8'h00);
        send_item(CMD_PAIR, 8'h80, 8'h7F);
        send_item(CMD_PAIR, 8'h01, 8'hFE);
        send_item(CMD_PAIR, 8'hFF, 8'h00);       // position at target length: ignored
        send_item(CMD_END, 8'h00, 8'h00);

        // Oversized targets rejected at begin, by either rule
        settle();
        set_config(ALL_ONES, 25'h1FF_FFFF, 32'd0);
        send_item(CMD_BEGIN, 8'h00, 8'h00);
        settle();
        set_config(ALL_ONES, TARGET_LIMIT, ALL_ONES);
        send_item(CMD_BEGIN, 8'h00, 8'h00);

        // Size limit 12: header and a two-byte literal fit exactly, the EOF
        // marker does not; the pair after that hits an idle block.
        settle();
        set_config(32'd0, TARGET_LIMIT, 32'd12);
        send_item(CMD_BEGIN, 8'h00, 8'h00);
        send_item(CMD_PAIR, 8'h11, 8'h11);
        send_item(CMD_PAIR, 8'h22, 8'h22);
        send_item(CMD_END, 8'h00, 8'h00);
        send_item(CMD_PAIR, 8'h33, 8'h00);

        // ---- random jobs ----
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            settle();
            if (!pressure_done && items_sent - random_start > RANDOM_ITEMS / 3) begin
                // short runs everywhere -> many records; receiver holds off
                // while the sender keeps offering, so the block fills up
                set_config(32'd200, 25'd120, ALL_ONES);
                hold_req = 1'b1;
                patch_job(120, 50, 0, 20, 0);
                pressure_done = 1'b1;
            end else begin
                case ($urandom_range(0, 15))
                    0:       src = 32'd0;
                    1:       src = ALL_ONES;
                    2:       src = $urandom();
                    default: src = $urandom_range(0, 48);
                endcase
                case ($urandom_range(0, 15))
                    0:       tgt = 25'd0;
                    1:       tgt = 25'h1FF_FFFF;
                    2:       tgt = TARGET_LIMIT;
                    3:       tgt = TARGET_LIMIT_SHORT;
                    4:       tgt = 25'($urandom());
                    default: tgt = 25'($urandom_range(1, 48));
                endcase
                case ($urandom_range(0, 15))
                    0:       lim = 32'd0;
                    1:       lim = $urandom();
                    2, 3, 4: lim = $urandom_range(5, 150);
                    default: lim = ALL_ONES;
                endcase
                // huge targets: a handful of pairs, then an early end
                if (tgt > 25'd64) begin
                    pairs = $urandom_range(0, 24);
                end else begin
                    case ($urandom_range(0, 7))
                        0:       pairs = $urandom_range(0, tgt);
                        1:       pairs = tgt + $urandom_range(1, 4);
                        default: pairs = tgt;
                    endcase
                end
                set_config(src, tgt, lim);
                patch_job(pairs, $urandom_range(10, 90), $urandom_range(0, 90),
                          $urandom_range(0, 90), ($urandom_range(0, 3) == 0) ? 5 : 0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("** ips_patch_record_builder_unit: PASSED **");
        end else begin
            $display("** ips_patch_record_builder_unit: FAILED **");
        end
        $finish;
    end

endmodule
